@@ hdl/bitmap_next_fit_block_allocator_assert.svh @@
// Assertion macros for the bitmap next-fit block allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BNFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define BNFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define BNFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BNFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/bnfa_pkg.sv @@
// Shared widths, codes and types of the bitmap next-fit block allocator.
// No dependencies; used by the interfaces and the top level.
package bnfa_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int CNT_W          = 11;
    localparam int BLK_W          = 10;
    localparam int OP_W           = 2;
    localparam int STAT_W         = 2;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = $clog2(WORD_W);
    localparam int CNT_MAX        = (1 << CNT_W) - 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

    localparam logic [OP_W-1:0] OP_ALLOC_NEXT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_GIVEN = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE        = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GWR,
        S_DONE
    } state_t;

endpackage

@@ hdl/bnfa_req_if.sv @@
// Request channel of the allocator: operation and block number.
// Depends on bnfa_pkg for field widths.
interface bnfa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bnfa_pkg::OP_W-1:0]     operation;
    logic [bnfa_pkg::BLK_W-1:0]    block_number;

    modport source (output valid, output operation, output block_number, input ready);
    modport sink   (input valid, input operation, input block_number, output ready);
endinterface

@@ hdl/bnfa_rsp_if.sv @@
// Response channel of the allocator: allocated block and status.
// Depends on bnfa_pkg for field widths.
interface bnfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bnfa_pkg::BLK_W-1:0]    allocated_block;
    logic [bnfa_pkg::STAT_W-1:0]   status;

    modport source (output valid, output allocated_block, output status, input ready);
    modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

@@ hdl/bnfa_cfg_if.sv @@
// Configuration write channel carrying the data block count.
// Depends on bnfa_pkg for the register width.
interface bnfa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bnfa_pkg::CNT_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/bitmap_next_fit_block_allocator.sv @@
// Top level of the bitmap next-fit block allocator with its word-wide bitmap memory.
// Depends on bnfa_pkg, the three channel interfaces and the assertion macro header.
//
// Usage: requests arrive on req (operation, block_number), one result per request
// leaves on rsp (allocated_block, status), and cfg writes the data block count.
// A request transfer happens only while the block is idle; it then works on that
// one request until its result is placed in the output register.
// Allocate-next scans the bitmap one 32-bit word per cycle through a single
// masked priority encoder, starting at the scan pointer and wrapping at the count.
// A scan visits at most ceil(count/32) + 1 bitmap words (33 for 1024 blocks), and
// allocate-given and free read, modify and write one bitmap word, then output;
// an out-of-range or unknown request skips the bitmap and goes to the output.
// Reset clears the control state, sets the count to 1024 and the pointer to 0;
// the bitmap reads as all free through per-word valid flags, so no clearing pass
// is needed. A stalled receiver holds the result in the output register; the
// next request is taken meanwhile but its result waits until the slot frees.
// Configuration writes are taken at any time and are meant for idle periods.
module bitmap_next_fit_block_allocator #(
    parameter int MAX_BLOCKS = bnfa_pkg::MAX_BLOCKS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bnfa_cfg_if.sink  cfg,
    bnfa_req_if.sink  req,
    bnfa_rsp_if.source rsp
);

`include "bitmap_next_fit_block_allocator_assert.svh"

    localparam int CNT_W  = bnfa_pkg::CNT_W;
    localparam int BLK_W  = bnfa_pkg::BLK_W;
    localparam int OP_W   = bnfa_pkg::OP_W;
    localparam int STAT_W = bnfa_pkg::STAT_W;
    localparam int WORD_W = bnfa_pkg::WORD_W;
    localparam int BIT_W  = bnfa_pkg::BIT_W;
    localparam int HI_W   = CNT_W - BIT_W;
    localparam int EFF_MAX = (MAX_BLOCKS < bnfa_pkg::CNT_MAX) ? MAX_BLOCKS : bnfa_pkg::CNT_MAX;
    localparam int PTR_W  = $clog2(EFF_MAX);
    localparam int NWORDS = (EFF_MAX + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        return (c > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : c;
    endfunction

    bnfa_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [WIDX_W-1:0] w0_reg, w0_next;
    logic [BIT_W-1:0]  sb_reg, sb_next;
    logic [WIDX_W-1:0] gen_word_reg, gen_word_next;
    logic              gen_first_reg, gen_first_next;
    logic              gen_done_reg, gen_done_next;
    logic              tag_v_reg, tag_v_next;
    logic [WIDX_W-1:0] tag_word_reg, tag_word_next;
    logic              tag_first_reg, tag_first_next;
    logic              tag_last_reg, tag_last_next;
    logic [BLK_W-1:0]  res_blk_reg, res_blk_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic              ovalid_reg, ovalid_next;
    logic [BLK_W-1:0]  oblk_reg, oblk_next;
    logic [STAT_W-1:0] ost_reg, ost_next;

    logic [WORD_W-1:0] mem [NWORDS];
    logic [NWORDS-1:0] wvalid_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic              rvalid_reg;

    logic              mem_re;
    logic [WIDX_W-1:0] mem_raddr;
    logic              mem_we;
    logic [WIDX_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  p11;
    logic [CNT_W-1:0]  sp;
    logic [CNT_W:0]    nx_base;
    logic [WIDX_W-1:0] nw;
    logic              gen_last;
    logic [WORD_W-1:0] rword;
    logic [HI_W-1:0]   tw_hi;
    logic [WORD_W-1:0] cand;
    logic              hit;
    logic [BIT_W-1:0]  enc;
    logic [CNT_W-1:0]  idx11;
    logic [CNT_W-1:0]  inc11;
    logic [WORD_W-1:0] gmask;
    logic              load;

    assign cnt_eff = eff_count(cnt_reg);
    assign p11     = CNT_W'(ptr_reg);
    assign sp      = (p11 >= cnt_eff) ? '0 : p11;
    assign rword   = rvalid_reg ? rdata_reg : '0;

    assign nx_base  = ((CNT_W + 1)'(gen_word_reg) + 1'b1) << BIT_W;
    assign nw       = (nx_base >= {1'b0, cnt_eff}) ? '0 : WIDX_W'(gen_word_reg + 1'b1);
    assign gen_last = (!gen_first_reg && (gen_word_reg == w0_reg))
                   || (gen_first_reg && (sb_reg == '0) && (nw == w0_reg));

    assign tw_hi = HI_W'(tag_word_reg);

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            logic in_range;
            logic pos_ok;
            in_range = (tw_hi < cnt_eff[CNT_W-1:BIT_W])
                    || ((tw_hi == cnt_eff[CNT_W-1:BIT_W]) && (BIT_W'(b) < cnt_eff[BIT_W-1:0]));
            if (tag_first_reg)
            begin
                pos_ok = (BIT_W'(b) >= sb_reg);
            end
            else if (tag_last_reg)
            begin
                pos_ok = (BIT_W'(b) < sb_reg);
            end
            else
            begin
                pos_ok = 1'b1;
            end
            cand[b] = !rword[b] && in_range && pos_ok;
        end
    end

    always_comb
    begin
        enc = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                enc = BIT_W'(b);
            end
        end
    end

    assign hit   = tag_v_reg && (|cand);
    assign idx11 = (CNT_W'(tag_word_reg) << BIT_W) | CNT_W'(enc);
    assign inc11 = idx11 + 1'b1;
    assign gmask = WORD_W'(1) << blk_reg[BIT_W-1:0];

    assign req.ready           = (state_reg == bnfa_pkg::S_IDLE);
    assign cfg.ready           = 1'b1;
    assign rsp.valid           = ovalid_reg;
    assign rsp.allocated_block = oblk_reg;
    assign rsp.status          = ost_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        op_next        = op_reg;
        blk_next       = blk_reg;
        w0_next        = w0_reg;
        sb_next        = sb_reg;
        gen_word_next  = gen_word_reg;
        gen_first_next = gen_first_reg;
        gen_done_next  = gen_done_reg;
        tag_v_next     = 1'b0;
        tag_word_next  = tag_word_reg;
        tag_first_next = tag_first_reg;
        tag_last_next  = tag_last_reg;
        res_blk_next   = res_blk_reg;
        res_st_next    = res_st_reg;
        mem_re         = 1'b0;
        mem_raddr      = gen_word_reg;
        mem_we         = 1'b0;
        mem_waddr      = tag_word_reg;
        mem_wdata      = rword | (WORD_W'(1) << enc);
        load           = 1'b0;

        unique case (state_reg)
            bnfa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.operation;
                    blk_next = req.block_number;
                    case (req.operation) inside
                        bnfa_pkg::OP_ALLOC_NEXT:
                        begin
                            if (cnt_eff == '0)
                            begin
                                res_blk_next = '0;
                                res_st_next  = bnfa_pkg::STAT_NOSPACE;
                                state_next   = bnfa_pkg::S_DONE;
                            end
                            else
                            begin
                                w0_next        = WIDX_W'(sp >> BIT_W);
                                sb_next        = sp[BIT_W-1:0];
                                gen_word_next  = WIDX_W'(sp >> BIT_W);
                                gen_first_next = 1'b1;
                                gen_done_next  = 1'b0;
                                state_next     = bnfa_pkg::S_SCAN;
                            end
                        end
                        bnfa_pkg::OP_ALLOC_GIVEN, bnfa_pkg::OP_FREE:
                        begin
                            if (CNT_W'(req.block_number) >= cnt_eff)
                            begin
                                res_blk_next = req.block_number;
                                res_st_next  = bnfa_pkg::STAT_RANGE;
                                state_next   = bnfa_pkg::S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = WIDX_W'(req.block_number >> BIT_W);
                                state_next = bnfa_pkg::S_GWR;
                            end
                        end
                        default:
                        begin
                            res_blk_next = req.block_number;
                            res_st_next  = bnfa_pkg::STAT_RANGE;
                            state_next   = bnfa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bnfa_pkg::S_SCAN:
            begin
                if (!gen_done_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = gen_word_reg;
                    tag_v_next     = 1'b1;
                    tag_word_next  = gen_word_reg;
                    tag_first_next = gen_first_reg;
                    tag_last_next  = gen_last;
                    gen_word_next  = nw;
                    gen_first_next = 1'b0;
                    gen_done_next  = gen_last;
                end
                if (hit)
                begin
                    mem_we       = 1'b1;
                    ptr_next     = (inc11 >= cnt_eff) ? '0 : PTR_W'(inc11);
                    res_blk_next = BLK_W'(idx11);
                    res_st_next  = bnfa_pkg::STAT_OK;
                    state_next   = bnfa_pkg::S_DONE;
                end
                else if (tag_v_reg && tag_last_reg)
                begin
                    res_blk_next = '0;
                    res_st_next  = bnfa_pkg::STAT_NOSPACE;
                    state_next   = bnfa_pkg::S_DONE;
                end
            end
            bnfa_pkg::S_GWR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = WIDX_W'(blk_reg >> BIT_W);
                mem_wdata    = (op_reg == bnfa_pkg::OP_ALLOC_GIVEN) ? (rword | gmask)
                                                                    : (rword & ~gmask);
                res_blk_next = blk_reg;
                res_st_next  = bnfa_pkg::STAT_OK;
                state_next   = bnfa_pkg::S_DONE;
            end
            bnfa_pkg::S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = bnfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bnfa_pkg::S_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            cnt_next = cfg.data;
            if (CNT_W'(ptr_reg) >= eff_count(cfg.data))
            begin
                ptr_next = '0;
            end
        end

        ovalid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : ovalid_reg);
        oblk_next   = load ? res_blk_reg : oblk_reg;
        ost_next    = load ? res_st_reg : ost_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bnfa_pkg::S_IDLE;
            cnt_reg       <= bnfa_pkg::COUNT_RESET;
            ptr_reg       <= '0;
            gen_first_reg <= 1'b0;
            gen_done_reg  <= 1'b0;
            tag_v_reg     <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            gen_first_reg <= gen_first_next;
            gen_done_reg  <= gen_done_next;
            tag_v_reg     <= tag_v_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        blk_reg       <= blk_next;
        w0_reg        <= w0_next;
        sb_reg        <= sb_next;
        gen_word_reg  <= gen_word_next;
        tag_word_reg  <= tag_word_next;
        tag_first_reg <= tag_first_next;
        tag_last_reg  <= tag_last_next;
        res_blk_reg   <= res_blk_next;
        res_st_reg    <= res_st_next;
        oblk_reg      <= oblk_next;
        ost_reg       <= ost_next;
    end

    // Words that were never written read as all free.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                wvalid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rvalid_reg <= wvalid_reg[mem_raddr];
            end
        end
    end

    `BNFA_ASSERT_IMP(a_ptr_in_range, clk, rst_n,
        (state_reg == bnfa_pkg::S_IDLE) && (cnt_eff != '0), p11 < cnt_eff)
    `BNFA_ASSERT_NXT(a_scan_ends_at_last, clk, rst_n,
        (state_reg == bnfa_pkg::S_SCAN) && tag_v_reg && tag_last_reg,
        state_reg != bnfa_pkg::S_SCAN)
    `BNFA_ASSERT_IMP(a_out_from_done, clk, rst_n,
        $rose(ovalid_reg), $past(state_reg) == bnfa_pkg::S_DONE)
    `BNFA_ASSERT_IMP(a_nospace_zero, clk, rst_n,
        load && (res_st_reg == bnfa_pkg::STAT_NOSPACE), res_blk_reg == '0)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the bitmap next-fit block allocator: it mirrors the used map
// and scan pointer, predicts each result, and checks every response transfer.
// Depends on bnfa_pkg, the three channel interfaces and the bitmap_next_fit_block_allocator top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bnfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int QUIET_TAIL     = 60;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [bnfa_pkg::BLK_W-1:0]  block;
        logic [bnfa_pkg::STAT_W-1:0] status;
    } outcome_t;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t                 kind;
        logic [bnfa_pkg::OP_W-1:0]  op;
        logic [bnfa_pkg::BLK_W-1:0] blk;
        logic [bnfa_pkg::CNT_W-1:0] count;
    } step_t;

    logic clk;
    logic rst_n;

    bnfa_cfg_if cfg_ch ();
    bnfa_req_if req_ch ();
    bnfa_rsp_if rsp_ch ();

    bitmap_next_fit_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    step_t                      request_plan[$];
    outcome_t                   outcome_q[$];
    bit                         used_bits[bnfa_pkg::MAX_BLOCKS_DEF];
    logic [bnfa_pkg::BLK_W-1:0] scan_ptr;
    logic [bnfa_pkg::CNT_W-1:0] managed_count;
    int                         plan_limit;
    int                         errors;
    int                         idle_cycles;
    int                         results_seen;
    int                         gap_left;
    int                         stall_left;
    int                         hold_left;
    bit                         long_hold_done;
    bit                         quiet_tail;

    function automatic int usable_blocks(logic [bnfa_pkg::CNT_W-1:0] count);
        return (int'(count) > bnfa_pkg::MAX_BLOCKS_DEF) ? bnfa_pkg::MAX_BLOCKS_DEF
                                                       : int'(count);
    endfunction

    function automatic outcome_t predict_allocation(logic [bnfa_pkg::OP_W-1:0] op,
                                                    logic [bnfa_pkg::BLK_W-1:0] blk);
        int limit;
        int pos;
        int nxt;
        outcome_t res;
        limit = usable_blocks(managed_count);
        res.block = blk;
        res.status = bnfa_pkg::STAT_OK;
        if (op == bnfa_pkg::OP_ALLOC_NEXT)
        begin
            res.block = '0;
            res.status = bnfa_pkg::STAT_NOSPACE;
            pos = (int'(scan_ptr) >= limit) ? 0 : int'(scan_ptr);
            for (int tries = 0; tries < limit; tries++)
            begin
                nxt = (pos + 1 >= limit) ? 0 : pos + 1;
                if (!used_bits[pos])
                begin
                    used_bits[pos] = 1'b1;
                    res.block = bnfa_pkg::BLK_W'(pos);
                    res.status = bnfa_pkg::STAT_OK;
                    scan_ptr = bnfa_pkg::BLK_W'(nxt);
                    break;
                end
                pos = nxt;
            end
        end
        else if (op == bnfa_pkg::OP_ALLOC_GIVEN || op == bnfa_pkg::OP_FREE)
        begin
            if (int'(blk) >= limit)
            begin
                res.status = bnfa_pkg::STAT_RANGE;
            end
            else
            begin
                used_bits[blk] = (op == bnfa_pkg::OP_ALLOC_GIVEN);
            end
        end
        else
        begin
            res.status = bnfa_pkg::STAT_RANGE;
        end
        return res;
    endfunction

    function automatic void load_block_count(logic [bnfa_pkg::CNT_W-1:0] count);
        managed_count = count;
        if (int'(scan_ptr) >= usable_blocks(count))
        begin
            scan_ptr = '0;
        end
    endfunction

    function automatic void plan_request(logic [bnfa_pkg::OP_W-1:0] op, int blk);
        step_t step;
        step.kind = STEP_REQ;
        step.op = op;
        step.blk = bnfa_pkg::BLK_W'(blk);
        step.count = '0;
        request_plan.push_back(step);
    endfunction

    function automatic void plan_config(int count);
        step_t step;
        step.kind = STEP_CFG;
        step.op = bnfa_pkg::OP_ALLOC_NEXT;
        step.blk = '0;
        step.count = bnfa_pkg::CNT_W'(count);
        request_plan.push_back(step);
        plan_limit = usable_blocks(bnfa_pkg::CNT_W'(count));
    endfunction

    function automatic void plan_drain();
        step_t step;
        step.kind = STEP_DRAIN;
        step.op = bnfa_pkg::OP_ALLOC_NEXT;
        step.blk = '0;
        step.count = '0;
        request_plan.push_back(step);
    endfunction

    function automatic int pick_block();
        int roll;
        roll = $urandom_range(0, 9);
        if (plan_limit == 0 || roll < 2)
        begin
            return $urandom_range(0, bnfa_pkg::MAX_BLOCKS_DEF - 1);
        end
        else if (roll == 2)
        begin
            return plan_limit - 1;
        end
        return $urandom_range(0, plan_limit - 1);
    endfunction

    function automatic void plan_random_phase();
        int items;
        int roll;
        int count;
        logic [bnfa_pkg::OP_W-1:0] op;
        roll = $urandom_range(0, 9);
        if (roll < 5)
        begin
            count = $urandom_range(1, 48);
        end
        else if (roll == 5)
        begin
            count = 1024;
        end
        else if (roll == 6)
        begin
            count = $urandom_range(0, bnfa_pkg::CNT_MAX);
        end
        else if (roll == 7)
        begin
            count = $urandom_range(1, 2);
        end
        else
        begin
            count = $urandom_range(49, 1023);
        end
        plan_config(count);
        items = $urandom_range(30, 70);
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2 && $urandom_range(0, 2) == 0)
            begin
                plan_drain();
            end
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                op = bnfa_pkg::OP_ALLOC_NEXT;
            end
            else if (roll < 65)
            begin
                op = bnfa_pkg::OP_ALLOC_GIVEN;
            end
            else if (roll < 95)
            begin
                op = bnfa_pkg::OP_FREE;
            end
            else
            begin
                op = OP_UNUSED;
            end
            plan_request(op, pick_block());
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b1;
        rst_n <= 1'b0;
        used_bits = '{default: 1'b0};
        scan_ptr = '0;
        managed_count = bnfa_pkg::COUNT_RESET;
        plan_limit = usable_blocks(bnfa_pkg::COUNT_RESET);
        errors = 0;
        idle_cycles = 0;
        results_seen = 0;
        gap_left = 0;
        stall_left = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        quiet_tail = 1'b0;

        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 1023);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_GIVEN, 1023);
        plan_request(bnfa_pkg::OP_FREE, 1023);
        plan_request(bnfa_pkg::OP_FREE, 500);
        plan_request(bnfa_pkg::OP_ALLOC_GIVEN, 0);
        plan_request(OP_UNUSED, 1023);
        plan_request(OP_UNUSED, 0);
        plan_request(bnfa_pkg::OP_FREE, 1);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_config(0);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_GIVEN, 0);
        plan_request(bnfa_pkg::OP_FREE, 1023);
        plan_config(bnfa_pkg::CNT_MAX);
        plan_request(bnfa_pkg::OP_ALLOC_GIVEN, 1023);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_config(4);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_GIVEN, 4);
        plan_request(bnfa_pkg::OP_FREE, 2);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_config(8);
        plan_request(bnfa_pkg::OP_FREE, 7);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_config(1);
        plan_request(bnfa_pkg::OP_FREE, 0);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);

        while (request_plan.size() < 530)
        begin
            plan_random_phase();
        end
        plan_config(1024);
        for (int i = 0; i < 20; i++)
        begin
            plan_request(bnfa_pkg::OP_ALLOC_NEXT, 0);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_plan.size() != 0 || outcome_q.size() != 0
               || req_ch.valid || cfg_ch.valid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.operation <= bnfa_pkg::OP_ALLOC_NEXT;
            req_ch.block_number <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.data <= bnfa_pkg::COUNT_RESET;
        end
        else
        begin : drive
            logic offer_req;
            logic offer_cfg;
            step_t step;
            offer_req = req_ch.valid && !req_ch.ready;
            offer_cfg = cfg_ch.valid && !cfg_ch.ready;
            if (request_plan.size() < QUIET_TAIL)
            begin
                quiet_tail = 1'b1;
            end
            if (!offer_req && !offer_cfg)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (request_plan.size() != 0)
                begin
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                    begin
                        gap_left = $urandom_range(0, 16);
                    end
                    else if (request_plan[0].kind == STEP_REQ)
                    begin
                        step = request_plan.pop_front();
                        req_ch.operation <= step.op;
                        req_ch.block_number <= step.blk;
                        offer_req = 1'b1;
                    end
                    else if (!req_ch.valid && !cfg_ch.valid && outcome_q.size() == 0)
                    begin
                        step = request_plan.pop_front();
                        if (step.kind == STEP_CFG)
                        begin
                            cfg_ch.data <= step.count;
                            offer_cfg = 1'b1;
                        end
                    end
                end
            end
            req_ch.valid <= offer_req;
            cfg_ch.valid <= offer_cfg;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin : receive
            logic take;
            take = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (!long_hold_done && results_seen >= 150)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 16);
            end
            else
            begin
                take = 1'b1;
            end
            rsp_ch.ready <= take;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin : observe
            outcome_t want;
            logic moved;
            moved = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                outcome_q.push_back(predict_allocation(req_ch.operation,
                                                       req_ch.block_number));
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                load_block_count(cfg_ch.data);
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected result transfer: block %0d status %0d",
                                 rsp_ch.allocated_block, rsp_ch.status);
                    end
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp_ch.allocated_block !== want.block
                        || rsp_ch.status !== want.status)
                    begin
                        if (errors < 10)
                        begin
                            $display({"mismatch: expected block %0d status %0d, ",
                                      "got block %0d status %0d"},
                                     want.block, want.status,
                                     rsp_ch.allocated_block, rsp_ch.status);
                        end
                        errors++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bnfa_pkg.sv
hdl/bnfa_req_if.sv
hdl/bnfa_rsp_if.sv
hdl/bnfa_cfg_if.sv
hdl/bitmap_next_fit_block_allocator.sv
verif/testbench.sv
